// ===== design/atw_pkg.sv =====
// Shared constants for the axis twist interpolator.
// Field widths, operation codes and register indexes; no dependencies.
package atw_pkg;

  localparam int NUM_POINTS_DEF = 8;
  localparam int POS_W          = 21;
  localparam int SPACING_W      = 20;
  localparam int ENTRY_W        = 16;
  localparam int INDEX_W        = 3;
  localparam int QUO_W          = 18;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_ENABLE  = 2'd0;
  localparam logic [1:0] REG_START   = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

endpackage

// ===== design/atw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module atw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/atw_div.sv =====
// Pipelined restoring divider producing QW quotient bits, one bit per stage.
// The user must hold the divisor static while items are in flight; the block does not enforce it. Uses atw_pkg.
module atw_div #(
  parameter int NW = 39,
  parameter int DW = 20,
  parameter int QW = atw_pkg::QUO_W,
  parameter int TW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [TW-1:0] tag_o
);
  import atw_pkg::*;

  localparam int HW = NW - QW;

  logic          vld [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [QW-1:0] low [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic          ovf [QW+1];
  logic [TW-1:0] tag [QW+1];
  logic [HW-1:0] hi;

  always_comb begin
    hi     = num_i[NW-1:QW];
    vld[0] = vld_i;
    ovf[0] = hi >= HW'(den_i);
    rem[0] = hi[DW-1:0];
    low[0] = num_i[QW-1:0];
    quo[0] = '0;
    tag[0] = tag_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    always_comb begin
      trial = {rem[s], low[s][QW-1-s]};
      fits  = trial >= {1'b0, den_i};
      rem_d = fits ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
      quo_d = quo[s];
      quo_d[QW-1-s] = fits;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem[s+1] <= rem_d;
      low[s+1] <= low[s];
      quo[s+1] <= quo_d;
      ovf[s+1] <= ovf[s];
      tag[s+1] <= tag[s];
    end
  end

  assign vld_o = vld[QW];
  assign quo_o = quo[QW];
  assign ovf_o = ovf[QW];
  assign tag_o = tag[QW];

endmodule

// ===== design/axis_twist_interpolator.sv =====
// Throughput: one transfer per cycle; busy stays low and the result cannot be stalled.
// Segment search and interpolation each run through a bit-per-stage divider pipeline.
// Loads write the table RAM in program order at the read stage of the pipeline.
// Reset clears control state (enable resets to one) and marks every table entry invalid, so it reads as zero.
// Top level; uses atw_pkg, atw_div and atw_ram.
module axis_twist_interpolator #(
  parameter int NUM_POINTS = atw_pkg::NUM_POINTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op_i,
  input  logic signed [atw_pkg::POS_W-1:0]    x_pos_i,
  input  logic [atw_pkg::INDEX_W-1:0]         entry_index_i,
  input  logic signed [atw_pkg::ENTRY_W-1:0]  entry_value_i,
  output logic                                done_o,
  output logic signed [atw_pkg::ENTRY_W-1:0]  z_correction_o,
  output logic                                clipped_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import atw_pkg::*;

  localparam int AW   = $clog2(NUM_POINTS);
  localparam int IW   = $clog2(NUM_POINTS - 1);
  localparam int DLW  = POS_W + 1;
  localparam int NWI  = POS_W + IW;
  localparam int EXW  = POS_W + IW + 2;
  localparam int DFW  = ENTRY_W + 1;
  localparam int NWQ  = DLW + DFW;
  localparam int SUMW = QUO_W + 3;

  typedef struct packed {
    logic                     op;
    logic [INDEX_W-1:0]       idx;
    logic signed [ENTRY_W-1:0] val;
    logic signed [DLW-1:0]    delta;
    logic                     neg;
  } item_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] a;
    logic                      sign;
  } qtag_t;

  // Configuration registers.
  logic                 en_q;
  logic [POS_W-1:0]     start_q;
  logic [SPACING_W-1:0] sp_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b1;
      start_q <= '0;
      sp_q    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ENABLE:  en_q    <= pwdata[0];
        REG_START:   start_q <= pwdata[POS_W-1:0];
        REG_SPACING: sp_q    <= pwdata[SPACING_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE:  prdata = {31'b0, en_q};
      REG_START:   prdata = {{(32-POS_W){start_q[POS_W-1]}}, start_q};
      REG_SPACING: prdata = {{(32-SPACING_W){1'b0}}, sp_q};
      default:     prdata = '0;
    endcase
  end

  // Stage A: distance from the first table point.
  logic  a_vld_q;
  item_t a_item_q;
  logic signed [DLW-1:0] dist_d;

  assign dist_d = $signed({x_pos_i[POS_W-1], x_pos_i}) - $signed({start_q[POS_W-1], start_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    a_item_q.op    <= op_i;
    a_item_q.idx   <= entry_index_i;
    a_item_q.val   <= entry_value_i;
    a_item_q.delta <= dist_d;
    a_item_q.neg   <= dist_d[DLW-1];
  end

  // Segment search.
  logic           si_vld;
  logic [IW-1:0]  si_quo;
  logic           si_ovf;
  item_t          si_item;
  logic [NWI-1:0] si_num;

  assign si_num = a_item_q.neg ? '0 : NWI'(a_item_q.delta[POS_W-1:0]);

  atw_div #(.NW(NWI), .DW(SPACING_W), .QW(IW), .TW($bits(item_t))) u_seg_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (a_vld_q),
    .num_i (si_num),
    .den_i (sp_q),
    .tag_i (a_item_q),
    .vld_o (si_vld),
    .quo_o (si_quo),
    .ovf_o (si_ovf),
    .tag_o (si_item)
  );

  logic [IW-1:0] seg;
  logic          ld_we;
  logic          qry;
  logic [AW-1:0] ld_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  logic [NUM_POINTS-1:0] tv_q;

  always_comb begin
    if (si_item.neg) begin
      seg = '0;
    end else if (si_ovf || si_quo > IW'(NUM_POINTS - 2)) begin
      seg = IW'(NUM_POINTS - 2);
    end else begin
      seg = si_quo;
    end
    ld_we     = si_vld && si_item.op == OP_LOAD && 32'(si_item.idx) < NUM_POINTS;
    qry       = si_vld && si_item.op == OP_QUERY;
    ld_addr   = AW'(si_item.idx);
    rd_addr_a = AW'(seg);
    rd_addr_b = AW'(seg) + AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (ld_we) begin
      tv_q[ld_addr] <= 1'b1;
    end
  end

  logic [ENTRY_W-1:0] ram_a;
  logic [ENTRY_W-1:0] ram_b;

  atw_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_POINTS)) u_ram_lo (
    .clk_i  (clk_i),
    .we_i   (ld_we),
    .waddr_i(ld_addr),
    .wdata_i(si_item.val),
    .raddr_i(rd_addr_a),
    .rdata_o(ram_a)
  );

  atw_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_POINTS)) u_ram_hi (
    .clk_i  (clk_i),
    .we_i   (ld_we),
    .waddr_i(ld_addr),
    .wdata_i(si_item.val),
    .raddr_i(rd_addr_b),
    .rdata_o(ram_b)
  );

  // Stage B: table read in flight.
  logic                  b_vld_q;
  logic [IW-1:0]         b_seg_q;
  logic signed [DLW-1:0] b_dist_q;
  logic                  b_va_q;
  logic                  b_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= qry;
    end
  end

  always_ff @(posedge clk_i) begin
    b_seg_q  <= seg;
    b_dist_q <= si_item.delta;
    b_va_q   <= tv_q[rd_addr_a];
    b_vb_q   <= tv_q[rd_addr_b];
  end

  // Stage C: offset inside the segment and endpoint difference.
  logic                      c_vld_q;
  logic signed [DLW-1:0]     c_r_q;
  logic signed [ENTRY_W-1:0] c_a_q;
  logic signed [DFW-1:0]     c_diff_q;
  logic signed [ENTRY_W-1:0] pt_a;
  logic signed [ENTRY_W-1:0] pt_b;
  logic signed [EXW-1:0]     r_full;

  always_comb begin
    pt_a   = b_va_q ? $signed(ram_a) : '0;
    pt_b   = b_vb_q ? $signed(ram_b) : '0;
    r_full = EXW'(b_dist_q) - $signed(EXW'(b_seg_q * sp_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_r_q    <= r_full[DLW-1:0];
    c_a_q    <= pt_a;
    c_diff_q <= DFW'(pt_b) - DFW'(pt_a);
  end

  // Stage D: numerator of the interpolation.
  logic                      d_vld_q;
  logic signed [NWQ-1:0]     d_num_q;
  logic signed [ENTRY_W-1:0] d_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_num_q <= NWQ'(c_r_q) * NWQ'(c_diff_q);
    d_a_q   <= c_a_q;
  end

  // A negative numerator divides as its one's complement, which gives the floor.
  logic             iq_vld;
  logic [QUO_W-1:0] iq_quo;
  logic             iq_ovf;
  qtag_t            iq_tag;
  qtag_t            dq_tag;
  logic [NWQ-1:0]   iq_num;

  assign iq_num      = d_num_q ^ {NWQ{d_num_q[NWQ-1]}};
  assign dq_tag.a    = d_a_q;
  assign dq_tag.sign = d_num_q[NWQ-1];

  atw_div #(.NW(NWQ), .DW(SPACING_W), .QW(QUO_W), .TW($bits(qtag_t))) u_interp_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (d_vld_q),
    .num_i (iq_num),
    .den_i (sp_q),
    .tag_i (dq_tag),
    .vld_o (iq_vld),
    .quo_o (iq_quo),
    .ovf_o (iq_ovf),
    .tag_o (iq_tag)
  );

  // Stage E: sum, saturation (zero when disabled or the spacing is zero) and result register.
  logic signed [SUMW-1:0]    quo_s;
  logic signed [SUMW-1:0]    sum;
  logic signed [ENTRY_W-1:0] z_d;
  logic                      clip_d;
  logic                      done_q;
  logic signed [ENTRY_W-1:0] z_q;
  logic                      clip_q;

  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(32767);
  localparam logic signed [SUMW-1:0] SAT_LO = -SUMW'(32768);

  always_comb begin
    quo_s = iq_tag.sign ? ~$signed(SUMW'(iq_quo)) : $signed(SUMW'(iq_quo));
    sum   = SUMW'(iq_tag.a) + quo_s;
    priority if (!en_q || sp_q == '0) begin
      z_d    = '0;
      clip_d = 1'b0;
    end else if (iq_ovf) begin
      z_d    = iq_tag.sign ? -16'sd32768 : 16'sd32767;
      clip_d = 1'b1;
    end else if (sum > SAT_HI) begin
      z_d    = 16'sd32767;
      clip_d = 1'b1;
    end else if (sum < SAT_LO) begin
      z_d    = -16'sd32768;
      clip_d = 1'b1;
    end else begin
      z_d    = sum[ENTRY_W-1:0];
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= iq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q    <= z_d;
    clip_q <= clip_d;
  end

  assign done_o         = done_q;
  assign z_correction_o = z_q;
  assign clipped_o      = done_q && clip_q;

`ifndef SYNTHESIS
  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clipped_o |-> (z_correction_o == 16'sd32767 || z_correction_o == -16'sd32768))
    else $error("clipped result is not at a saturation limit");

  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (!en_q || sp_q == '0)) |-> (z_correction_o == '0 && !clipped_o))
    else $error("disabled correction returned a nonzero result");

  a_load_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_we |=> tv_q[$past(ld_addr)])
    else $error("table write did not mark its entry valid");

  a_query_reaches_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qry |=> b_vld_q)
    else $error("query lost at the table read stage");
`endif

endmodule
